// File: design/kcmm_pkg.sv
package kcmm_pkg;

    // defaults for the table size
    localparam int NUM_KEYS_DEF   = 256;
    localparam int COUNT_BITS_DEF = 16;

    // fixed widths of the item fields
    localparam int KEY_W = 8;
    localparam int CNT_W = 16;

endpackage

// File: design/key_count_min_max_table.sv
// Key count table: one saturating counter per key, held in a synchronous
// memory with one read and one write port. Each input transaction
// increments or decrements the count of one key and produces exactly one
// result transaction giving the lowest-index key with the greatest count,
// the lowest-index key with the least nonzero count, both counts and an
// empty flag. After acceptance the addressed counter is read and written
// back, then every counter is scanned through the one memory read port,
// one entry per cycle, and the result is loaded. The next item can be
// accepted in the cycle after the result is loaded, so an item is taken
// only once the previous result is loaded. After reset a clearing pass
// writes zero to every entry, during which no item is accepted.
// A finished result waits in the output register, and the next item can be
// taken in meanwhile.
module key_count_min_max_table
    import kcmm_pkg::*;
#(
    parameter int NUM_KEYS   = NUM_KEYS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             mode,
    input  logic [KEY_W-1:0] key_id,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [KEY_W-1:0] max_key,
    output logic [KEY_W-1:0] min_key,
    output logic [CNT_W-1:0] max_count,
    output logic [CNT_W-1:0] min_count,
    output logic             is_empty
);

    localparam int KEY_BITS = $clog2(NUM_KEYS);
    localparam int IDX_W    = (KEY_BITS > KEY_W) ? KEY_BITS : KEY_W;
    localparam logic [KEY_BITS-1:0]   LAST_ADDR = KEY_BITS'(NUM_KEYS - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_RD     = 6'b000100,
        ST_SCAN   = 6'b001000,
        ST_FINISH = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    // count store
    logic [COUNT_BITS-1:0] mem [NUM_KEYS];

    state_t                state_reg, state_next;
    logic [KEY_BITS-1:0]   addr_reg, addr_next;
    logic                  scan_vld_reg, scan_vld_next;
    logic                  acc_any_reg, acc_any_next;
    logic                  out_valid_reg, out_valid_next;

    logic [COUNT_BITS-1:0] rd_data_reg;
    logic [KEY_BITS-1:0]   rd_idx_reg;
    logic                  mode_reg, key_ok_reg;
    logic [KEY_BITS-1:0]   key_idx_reg;
    logic [COUNT_BITS-1:0] acc_hi_reg, acc_hi_next, acc_lo_reg, acc_lo_next;
    logic [KEY_BITS-1:0]   acc_hi_key_reg, acc_hi_key_next;
    logic [KEY_BITS-1:0]   acc_lo_key_reg, acc_lo_key_next;
    logic [KEY_W-1:0]      max_key_reg, min_key_reg;
    logic [CNT_W-1:0]      max_count_reg, min_count_reg;
    logic                  is_empty_reg;

    logic [IDX_W-1:0]      key_ext;
    logic [KEY_BITS-1:0]   in_idx;
    logic                  in_key_ok;
    logic                  in_fire, out_load;
    logic [KEY_BITS-1:0]   rd_addr, wr_addr;
    logic [COUNT_BITS-1:0] wr_data;
    logic                  wr_en;

    // input key to memory index
    assign key_ext   = IDX_W'(key_id);
    assign in_idx    = key_ext[KEY_BITS-1:0];
    assign in_key_ok = 32'(key_id) < 32'(NUM_KEYS);

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // read address: addressed key when idle, else the sweep address
    assign rd_addr = (state_reg == ST_IDLE) ? in_idx : addr_reg;

    // write port: clearing pass or counter write-back
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = key_idx_reg;
        wr_data = rd_data_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = addr_reg;
                wr_data = '0;
            end
            ST_RD:
            begin
                wr_en = key_ok_reg;
                if (!mode_reg)
                begin
                    if (rd_data_reg != COUNT_TOP)
                        wr_data = rd_data_reg + 1'b1;
                end
                else
                begin
                    if (rd_data_reg != '0)
                        wr_data = rd_data_reg - 1'b1;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // memory, one read and one write port, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
        rd_idx_reg  <= rd_addr;
    end

    // sequencer and scan accumulators
    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        scan_vld_next   = (state_reg == ST_SCAN);
        acc_any_next    = acc_any_reg;
        acc_hi_next     = acc_hi_reg;
        acc_lo_next     = acc_lo_reg;
        acc_hi_key_next = acc_hi_key_reg;
        acc_lo_key_next = acc_lo_key_reg;
        out_valid_next  = out_valid_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        // fold one scanned counter into the running extremes
        if (scan_vld_reg && (rd_data_reg != '0))
        begin
            if (!acc_any_reg)
            begin
                acc_any_next    = 1'b1;
                acc_hi_next     = rd_data_reg;
                acc_lo_next     = rd_data_reg;
                acc_hi_key_next = rd_idx_reg;
                acc_lo_key_next = rd_idx_reg;
            end
            else
            begin
                if (rd_data_reg > acc_hi_reg)
                begin
                    acc_hi_next     = rd_data_reg;
                    acc_hi_key_next = rd_idx_reg;
                end
                if (rd_data_reg < acc_lo_reg)
                begin
                    acc_lo_next     = rd_data_reg;
                    acc_lo_key_next = rd_idx_reg;
                end
            end
        end

        case (state_reg)
            ST_CLEAR:
            begin
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LAST_ADDR)
                begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = ST_RD;
            end
            ST_RD:
            begin
                // write-back lands before the first scan read is issued
                acc_any_next = 1'b0;
                addr_next    = '0;
                state_next   = ST_SCAN;
            end
            ST_SCAN:
            begin
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LAST_ADDR)
                begin
                    addr_next  = '0;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            addr_reg      <= '0;
            scan_vld_reg  <= 1'b0;
            acc_any_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            scan_vld_reg  <= scan_vld_next;
            acc_any_reg   <= acc_any_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg    <= mode;
            key_ok_reg  <= in_key_ok;
            key_idx_reg <= in_idx;
        end
        acc_hi_reg     <= acc_hi_next;
        acc_lo_reg     <= acc_lo_next;
        acc_hi_key_reg <= acc_hi_key_next;
        acc_lo_key_reg <= acc_lo_key_next;
        if (out_load)
        begin
            is_empty_reg <= !acc_any_reg;
            if (acc_any_reg)
            begin
                max_key_reg   <= KEY_W'(acc_hi_key_reg);
                min_key_reg   <= KEY_W'(acc_lo_key_reg);
                max_count_reg <= CNT_W'(acc_hi_reg);
                min_count_reg <= CNT_W'(acc_lo_reg);
            end
            else
            begin
                max_key_reg   <= '0;
                min_key_reg   <= '0;
                max_count_reg <= '0;
                min_count_reg <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign max_key   = max_key_reg;
    assign min_key   = min_key_reg;
    assign max_count = max_count_reg;
    assign min_count = min_count_reg;
    assign is_empty  = is_empty_reg;

    // a new result only comes out of the done state
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside done state");

    // an accepted transaction always starts with the counter read
    a_accept_to_read: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_RD)
        else $error("accepted item did not move to counter read");

    // scan data is only folded in right after a scan read
    a_scan_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        scan_vld_reg |-> $past(state_reg == ST_SCAN))
        else $error("scan data valid without a scan read");

    // running extremes stay ordered and nonzero
    a_acc_order: assert property (@(posedge clk) disable iff (!rst_n)
        acc_any_reg |-> (acc_lo_reg != '0) && (acc_lo_reg <= acc_hi_reg))
        else $error("least count above greatest count");

endmodule

// File: tb/key_count_min_max_table_tb.sv
import kcmm_pkg::*;

// increment or decrement the addressed counter
typedef enum logic {
    OP_INC = 1'b0,
    OP_DEC = 1'b1
} count_op_e;

// one result transaction
typedef struct packed {
    logic [KEY_W-1:0] max_key;
    logic [KEY_W-1:0] min_key;
    logic [CNT_W-1:0] max_count;
    logic [CNT_W-1:0] min_count;
    logic             is_empty;
} extremes_t;

class count_scoreboard;
    longint unsigned count_top;
    longint unsigned tally[NUM_KEYS_DEF];
    extremes_t       due_results[$];
    int              errors;
    int              checked;

    function new();
        count_top = (64'd1 << COUNT_BITS_DEF) - 1;
        foreach (tally[k])
        begin
            tally[k] = 0;
        end
        errors  = 0;
        checked = 0;
    endfunction

    // scan every counter, lowest index wins a tie
    function extremes_t predict_extremes();
        extremes_t       r;
        bit              any;
        longint unsigned hi;
        longint unsigned lo;
        r   = '0;
        any = 1'b0;
        hi  = 0;
        lo  = 0;
        for (int k = 0; k < NUM_KEYS_DEF; k++)
        begin
            if (tally[k] == 0)
                continue;
            if (!any)
            begin
                any       = 1'b1;
                hi        = tally[k];
                lo        = tally[k];
                r.max_key = KEY_W'(k);
                r.min_key = KEY_W'(k);
            end
            else
            begin
                if (tally[k] > hi)
                begin
                    hi        = tally[k];
                    r.max_key = KEY_W'(k);
                end
                if (tally[k] < lo)
                begin
                    lo        = tally[k];
                    r.min_key = KEY_W'(k);
                end
            end
        end
        r.max_count = CNT_W'(hi);
        r.min_count = CNT_W'(lo);
        r.is_empty  = !any;
        return r;
    endfunction

    // apply an accepted input transaction and queue the result it causes
    function void note_item(count_op_e op, logic [KEY_W-1:0] key);
        if (int'(key) < NUM_KEYS_DEF)
        begin
            if (op == OP_INC)
            begin
                if (tally[key] < count_top)
                    tally[key]++;
            end
            else if (tally[key] != 0)
            begin
                tally[key]--;
            end
        end
        due_results.push_back(predict_extremes());
    endfunction

    task report_mismatch(string msg);
        errors++;
        $display("ERROR: result %0d: %s", checked, msg);
    endtask

    // compare a result transaction with the oldest one pending
    task check_result(extremes_t got);
        extremes_t want;
        if (due_results.size() == 0)
        begin
            report_mismatch("result with nothing pending");
            return;
        end
        want = due_results.pop_front();
        if (got.max_key !== want.max_key)
            report_mismatch($sformatf("max_key %0d, want %0d", got.max_key, want.max_key));
        if (got.min_key !== want.min_key)
            report_mismatch($sformatf("min_key %0d, want %0d", got.min_key, want.min_key));
        if (got.max_count !== want.max_count)
            report_mismatch($sformatf("max_count %0d, want %0d", got.max_count,
                                      want.max_count));
        if (got.min_count !== want.min_count)
            report_mismatch($sformatf("min_count %0d, want %0d", got.min_count,
                                      want.min_count));
        if (got.is_empty !== want.is_empty)
            report_mismatch($sformatf("is_empty %0b, want %0b", got.is_empty, want.is_empty));
        checked++;
    endtask
endclass

module key_count_min_max_table_tb;

    localparam int RANDOM_ITEMS = 750;
    localparam int PHASE_ITEMS  = 50;
    localparam int HOLD_CYCLES  = 3000;
    localparam int CYCLE_LIMIT  = 1000000;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    logic             mode      = 1'b0;
    logic [KEY_W-1:0] key_id    = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [KEY_W-1:0] max_key;
    logic [KEY_W-1:0] min_key;
    logic [CNT_W-1:0] max_count;
    logic [CNT_W-1:0] min_count;
    logic             is_empty;

    count_scoreboard board = new();
    logic            idle_on  = 1'b0;
    logic            hold_off = 1'b0;
    int              items_sent  = 0;
    int              stall_left  = 0;
    int              cycle_count = 0;

    key_count_min_max_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .key_id    (key_id),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .max_key   (max_key),
        .min_key   (min_key),
        .max_count (max_count),
        .min_count (min_count),
        .is_empty  (is_empty)
    );

    always #1 clk = ~clk;

    // offer one input transaction, called and returning at a falling edge
    task send_item(input count_op_e op, input logic [KEY_W-1:0] key);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        mode     <= op;
        key_id   <= key;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        board.note_item(op, key);
        items_sent++;
        @(negedge clk);
    endtask

    // random stall bursts on the result side, overridden by the long hold-off
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= !hold_off;
            end
        end
    end

    // long hold-off so the block fills up and stalls its input
    initial
    begin
        wait (items_sent >= 120);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready)
            board.check_result({max_key, min_key, max_count, min_count, is_empty});
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // stimulus
    initial
    begin
        logic [KEY_W-1:0] hot[6];
        count_op_e        op;
        logic [KEY_W-1:0] key;
        bit               grow;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty table, decrement of an absent key, extremes, ties, draining
        send_item(OP_DEC, 8'd0);
        send_item(OP_INC, 8'd255);
        send_item(OP_INC, 8'd0);
        send_item(OP_INC, 8'd0);
        send_item(OP_INC, 8'hAA);
        send_item(OP_INC, 8'h55);
        send_item(OP_INC, 8'h55);
        send_item(OP_INC, 8'h55);
        send_item(OP_DEC, 8'd255);
        send_item(OP_DEC, 8'd255);
        send_item(OP_INC, 8'd128);
        send_item(OP_INC, 8'd127);
        send_item(OP_DEC, 8'h55);
        send_item(OP_DEC, 8'd0);
        send_item(OP_DEC, 8'd0);
        send_item(OP_DEC, 8'hAA);
        send_item(OP_DEC, 8'd128);
        send_item(OP_DEC, 8'h55);
        send_item(OP_DEC, 8'h55);
        send_item(OP_DEC, 8'd127);
        send_item(OP_DEC, 8'd127);
        send_item(OP_INC, 8'd1);
        send_item(OP_INC, 8'd254);
        send_item(OP_DEC, 8'd1);
        send_item(OP_DEC, 8'd254);

        // random: grow then drain the same hot keys, with a share of stray keys
        for (int phase = 0; phase < RANDOM_ITEMS / PHASE_ITEMS; phase++)
        begin
            idle_on <= !(phase == 6 || phase >= RANDOM_ITEMS / PHASE_ITEMS - 3);
            grow = (phase % 2 == 0);
            if (grow)
            begin
                foreach (hot[h])
                begin
                    hot[h] = KEY_W'($urandom_range(0, 255));
                end
                if (phase % 4 == 0)
                    hot[0] = 8'd0;
                if (phase % 6 == 0)
                    hot[1] = 8'd255;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                op = ($urandom_range(0, 99) < (grow ? 75 : 25)) ? OP_INC : OP_DEC;
                if ($urandom_range(0, 9) < 8)
                    key = hot[$urandom_range(0, 5)];
                else
                    key = KEY_W'($urandom_range(0, 255));
                send_item(op, key);
            end
        end
        in_valid <= 1'b0;

        // drain and let the block settle
        while (board.due_results.size() != 0)
            @(posedge clk);
        repeat (NUM_KEYS_DEF + 16) @(posedge clk);

        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
